[rtl/hed_pkg.sv]
`default_nettype none

package hed_pkg;

    // Fixed sizes of the block.
    localparam int LEVELS           = 256;
    localparam int MAX_LINE_DEFAULT = 256;
    localparam int HEIGHT_LIMIT     = 256;
    localparam int QUEUE_DEPTH      = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_DITHER_MODE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_ENABLE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT      = 3'd4;

    localparam logic [8:0] RESET_LINE_WIDTH   = 9'd256;
    localparam logic [8:0] RESET_FRAME_HEIGHT = 9'd192;

    // Input opcodes.
    localparam logic [1:0] OP_BIN   = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    // Dither modes; every other code is the plain threshold.
    localparam logic [1:0] MODE_SIERRA = 2'd0;
    localparam logic [1:0] MODE_BAYER  = 2'd1;

    // Threshold for the signed sums.
    localparam logic signed [9:0] WHITE_CUTOFF = 10'sd128;

    // Division by three through a reciprocal, exact for values below 1024.
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    typedef enum logic [1:0] {
        KIND_BIN   = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_FRAME = 2'd2
    } kind_t;

    // One classified item waiting between front and back.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  bin;
        logic [15:0] cum;
        logic [7:0]  gray;
    } entry_t;

    typedef struct packed {
        logic [1:0]        dither_mode;
        logic signed [7:0] brightness_offset;
        logic              table_enable;
        logic [8:0]        line_width;
        logic [8:0]        frame_height;
    } cfg_t;

    // Write request into the line error store: one column and its left neighbor.
    typedef struct packed {
        logic       en;
        logic [7:0] col;
        logic [7:0] cur_data;
        logic       left_en;
        logic [7:0] left_data;
    } err_wr_t;

    // 8x8 ordered dither matrix, indexed by {row, column}.
    localparam logic signed [7:0] BAYER [64] = '{
        -8'sd128,   8'sd0,   -8'sd96,   8'sd32, -8'sd120,   8'sd8,   -8'sd88,   8'sd40,
          8'sd64, -8'sd64,    8'sd96,  -8'sd32,   8'sd72, -8'sd56,   8'sd104,  -8'sd24,
         -8'sd80,  8'sd48,  -8'sd112,   8'sd16,  -8'sd72,  8'sd56,  -8'sd104,   8'sd24,
         8'sd112, -8'sd16,    8'sd80,  -8'sd48,  8'sd120,  -8'sd8,    8'sd88,  -8'sd40,
        -8'sd116,  8'sd12,   -8'sd84,   8'sd44, -8'sd124,   8'sd4,   -8'sd92,   8'sd36,
          8'sd76, -8'sd52,   8'sd108,  -8'sd20,   8'sd68, -8'sd60,   8'sd100,  -8'sd28,
         -8'sd68,  8'sd60,  -8'sd100,   8'sd28,  -8'sd76,  8'sd52,  -8'sd108,   8'sd20,
         8'sd124,  -8'sd4,    8'sd92,  -8'sd36,  8'sd116, -8'sd12,    8'sd84,  -8'sd44
    };

endpackage

`default_nettype wire

[rtl/hed_in_if.sv]
`default_nettype none

// Input channel: histogram bins, pixels and frame starts.
interface hed_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  bin_index;
    logic [15:0] bin_count;
    logic [7:0]  gray_level;

    modport source (
        output valid, opcode, bin_index, bin_count, gray_level,
        input  ready
    );

    modport sink (
        input  valid, opcode, bin_index, bin_count, gray_level,
        output ready
    );
endinterface

`default_nettype wire

[rtl/hed_out_if.sv]
`default_nettype none

// Output channel: one-bit pixels with their position.
interface hed_out_if;
    logic       valid;
    logic       ready;
    logic       pixel_white;
    logic [7:0] column;
    logic [7:0] row;
    logic       line_end;
    logic       frame_end;

    modport source (
        output valid, pixel_white, column, row, line_end, frame_end,
        input  ready
    );

    modport sink (
        input  valid, pixel_white, column, row, line_end, frame_end,
        output ready
    );
endinterface

`default_nettype wire

[rtl/histogram_equalize_dither.sv]
// A pixel passes through the queue, stages 1, 2 and 3 and the output register before it
// shows on results. One transaction per cycle unless results stalls; the level table
// and the banked line error store each take one read and one write per cycle.
// Histogram, frame-start and unused-opcode transactions produce no result.
// Reset (rst_n low, asynchronous): registers return to their defaults, the level table
// to identity, the line error store to zero, and items.ready is low until reset ends.
`default_nettype none

module histogram_equalize_dither #(
    parameter int MAX_LINE = hed_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    hed_in_if.sink                               items,
    hed_out_if.source                            results,
    input  wire logic                            cfg_we,
    input  wire logic [hed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [hed_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hed_pkg::cfg_t   cfg_reg;
    logic            q_full;
    logic            push;
    hed_pkg::entry_t push_entry;
    logic            pop;
    logic            head_valid;
    hed_pkg::entry_t head;

    // Configuration registers; writes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dither_mode       <= hed_pkg::MODE_SIERRA;
            cfg_reg.brightness_offset <= '0;
            cfg_reg.table_enable      <= 1'b1;
            cfg_reg.line_width        <= hed_pkg::RESET_LINE_WIDTH;
            cfg_reg.frame_height      <= hed_pkg::RESET_FRAME_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hed_pkg::REG_DITHER_MODE:       cfg_reg.dither_mode       <= cfg_data[1:0];
                hed_pkg::REG_BRIGHTNESS_OFFSET: cfg_reg.brightness_offset <= cfg_data[7:0];
                hed_pkg::REG_TABLE_ENABLE:      cfg_reg.table_enable      <= cfg_data[0];
                hed_pkg::REG_LINE_WIDTH:        cfg_reg.line_width        <= cfg_data;
                hed_pkg::REG_FRAME_HEIGHT:      cfg_reg.frame_height      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    hed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    hed_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

`default_nettype wire

[rtl/hed_front.sv]
`default_nettype none

module hed_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    hed_in_if.sink              items,
    input  wire logic           q_full,
    output logic                push,
    output hed_pkg::entry_t     push_entry
);

    logic        live_reg;
    logic [15:0] cum_reg;
    logic [15:0] cum_next;
    logic        accept;

    // Hold off transactions until the first cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= 1'b1;
        end
    end

    assign items.ready = live_reg && !q_full;
    assign accept      = items.valid && items.ready;

    // Running cumulative sum; bin zero starts it over.
    always_comb
    begin
        if (items.bin_index == 8'd0)
        begin
            cum_next = items.bin_count;
        end
        else
        begin
            cum_next = cum_reg + items.bin_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cum_reg <= '0;
        end
        else if (accept && items.opcode == hed_pkg::OP_BIN)
        begin
            cum_reg <= cum_next;
        end
    end

    // Classify the transaction; unused opcodes are dropped here.
    always_comb
    begin
        push_entry.bin  = items.bin_index;
        push_entry.cum  = cum_next;
        push_entry.gray = items.gray_level;
        push_entry.kind = hed_pkg::KIND_PIXEL;
        push            = 1'b0;
        unique case (items.opcode)
            hed_pkg::OP_BIN:
            begin
                push_entry.kind = hed_pkg::KIND_BIN;
                push            = accept;
            end
            hed_pkg::OP_PIXEL:
            begin
                push_entry.kind = hed_pkg::KIND_PIXEL;
                push            = accept;
            end
            hed_pkg::OP_FRAME:
            begin
                push_entry.kind = hed_pkg::KIND_FRAME;
                push            = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/hed_queue.sv]
`default_nettype none

module hed_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire hed_pkg::entry_t  push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output hed_pkg::entry_t       head
);

    localparam int DEPTH = hed_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hed_pkg::entry_t slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/hed_err_store.sv]
`default_nettype none

module hed_err_store #(
    parameter int MAX_LINE = hed_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             clear,
    input  wire logic [7:0]       rd_col,
    input  wire hed_pkg::err_wr_t wr,
    output logic [7:0]            cur_val,
    output logic [7:0]            left_val
);

    // Even and odd columns sit in separate banks, so a column and its left
    // neighbor are always read or written through different ports.
    localparam int STORE_DEPTH = (MAX_LINE < 256) ? MAX_LINE : 256;
    localparam int BANK_AW     = $clog2((STORE_DEPTH + 1) / 2);
    localparam int BANK_DEPTH  = 2 ** BANK_AW;

    logic [7:0] rd_left_col;
    logic [7:0] wr_left_col;
    logic [7:0] bank_val [2];
    logic       sel_reg;

    assign rd_left_col = rd_col - 8'd1;
    assign wr_left_col = wr.col - 8'd1;

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        logic [7:0]            mem [BANK_DEPTH];
        logic [BANK_DEPTH-1:0] valid_reg;
        logic [BANK_AW-1:0]    rd_idx;
        logic [BANK_AW-1:0]    wr_idx;
        logic                  wr_en;
        logic [7:0]            wr_data;
        logic [7:0]            q_reg;
        logic [7:0]            fwd_reg;
        logic                  hit_reg;
        logic                  zero_reg;

        // Route the column or its left neighbor to this bank.
        always_comb
        begin
            if (rd_col[0] == 1'(b))
            begin
                rd_idx = rd_col[BANK_AW:1];
            end
            else
            begin
                rd_idx = rd_left_col[BANK_AW:1];
            end
            if (wr.col[0] == 1'(b))
            begin
                wr_en   = en && wr.en;
                wr_idx  = wr.col[BANK_AW:1];
                wr_data = wr.cur_data;
            end
            else
            begin
                wr_en   = en && wr.en && wr.left_en;
                wr_idx  = wr_left_col[BANK_AW:1];
                wr_data = wr.left_data;
            end
        end

        // Bank array with registered read, plus write-through capture.
        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_idx] <= wr_data;
            end
            if (en)
            begin
                q_reg    <= mem[rd_idx];
                fwd_reg  <= wr_data;
                hit_reg  <= wr_en && (wr_idx == rd_idx);
                zero_reg <= clear || !valid_reg[rd_idx];
            end
        end

        // Written flags; an entry never written since the last clear reads zero.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= '0;
            end
            else if (en && clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end

        assign bank_val[b] = hit_reg ? fwd_reg : (zero_reg ? 8'd0 : q_reg);
    end

    // Remember which bank held the column itself.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg <= rd_col[0];
        end
    end

    assign cur_val  = bank_val[sel_reg];
    assign left_val = bank_val[!sel_reg];

endmodule

`default_nettype wire

[rtl/hed_back.sv]
`default_nettype none

module hed_back #(
    parameter int MAX_LINE = hed_pkg::MAX_LINE_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hed_pkg::cfg_t   cfg,
    input  wire logic            head_valid,
    input  wire hed_pkg::entry_t head,
    output logic                 pop,
    hed_out_if.source            results
);

    localparam int         STORE_DEPTH  = (MAX_LINE < 256) ? MAX_LINE : 256;
    localparam logic [7:0] WIDTH_MAX_M1 = 8'(STORE_DEPTH - 1);

    logic adv;
    logic out_valid_reg;

    // The whole back pipeline moves when the output register can take a result.
    assign adv = !out_valid_reg || results.ready;
    assign pop = adv && head_valid;

    // ------------------------------------------------------------------
    // Stage 1: histogram product, level table read.
    // ------------------------------------------------------------------
    logic            s1_valid_reg;
    hed_pkg::entry_t s1_entry_reg;
    logic [23:0]     s1_prod255;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_entry_reg <= head;
        end
    end

    // cum * 255 as a shift and subtract.
    assign s1_prod255 = {s1_entry_reg.cum, 8'd0} - {8'd0, s1_entry_reg.cum};

    // ------------------------------------------------------------------
    // Stage 2: table write, level mapping, position counters.
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    hed_pkg::kind_t       s2_kind_reg;
    logic [7:0]           s2_bin_reg;
    logic [7:0]           s2_gray_reg;
    logic [9:0]           s2_z_reg;
    logic [19:0]          s2_prod3;
    logic [8:0]           s2_quot;
    logic [7:0]           tbl_data;
    logic                 tbl_we;
    logic [7:0]           tbl_mem [hed_pkg::LEVELS];
    logic [hed_pkg::LEVELS-1:0] tbl_valid_reg;
    logic [7:0]           tbl_q_reg;
    logic [7:0]           tbl_fwd_reg;
    logic                 tbl_hit_reg;
    logic                 tbl_ok_reg;
    logic [7:0]           mapped;
    logic signed [9:0]    bright_sum;
    logic [7:0]           level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_entry_reg.kind;
            s2_bin_reg  <= s1_entry_reg.bin;
            s2_gray_reg <= s1_entry_reg.gray;
            s2_z_reg    <= s1_prod255[23:14];
        end
    end

    // Table entry: floor(z / 3), saturated to the 8-bit range.
    assign s2_prod3 = 20'(s2_z_reg) * 20'(hed_pkg::RECIP3);
    assign s2_quot  = s2_prod3[hed_pkg::RECIP3_SHIFT +: 9];
    assign tbl_data = s2_quot[8] ? 8'd255 : s2_quot[7:0];
    assign tbl_we   = adv && s2_valid_reg && (s2_kind_reg == hed_pkg::KIND_BIN);

    // Level table memory; a same-cycle write to the read address is forwarded.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[s2_bin_reg] <= tbl_data;
        end
        if (adv)
        begin
            tbl_q_reg   <= tbl_mem[s1_entry_reg.gray];
            tbl_fwd_reg <= tbl_data;
            tbl_hit_reg <= tbl_we && (s2_bin_reg == s1_entry_reg.gray);
            tbl_ok_reg  <= tbl_valid_reg[s1_entry_reg.gray];
        end
    end

    // Entries not yet written read as the identity mapping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (tbl_we)
        begin
            tbl_valid_reg[s2_bin_reg] <= 1'b1;
        end
    end

    // Map through the table when it is enabled, add the brightness offset and saturate.
    always_comb
    begin
        if (!cfg.table_enable)
        begin
            mapped = s2_gray_reg;
        end
        else if (tbl_hit_reg)
        begin
            mapped = tbl_fwd_reg;
        end
        else if (tbl_ok_reg)
        begin
            mapped = tbl_q_reg;
        end
        else
        begin
            mapped = s2_gray_reg;
        end
        bright_sum = $signed({2'b00, mapped})
                   + $signed({{2{cfg.brightness_offset[7]}}, cfg.brightness_offset});
        if (bright_sum < 10'sd0)
        begin
            level = 8'd0;
        end
        else if (bright_sum > 10'sd255)
        begin
            level = 8'd255;
        end
        else
        begin
            level = bright_sum[7:0];
        end
    end

    // Position counters.
    logic [7:0] col_cnt_reg;
    logic [7:0] row_cnt_reg;
    logic [2:0] bay_row_reg;
    logic [2:0] bay_col_reg;
    logic [7:0] width_m1;
    logic [7:0] height_m1;
    logic [7:0] col;
    logic [7:0] row;
    logic       lend;
    logic       fend;
    logic       s2_pixel;
    logic       bayer_mode;

    assign s2_pixel   = s2_valid_reg && (s2_kind_reg == hed_pkg::KIND_PIXEL);
    assign bayer_mode = (cfg.dither_mode == hed_pkg::MODE_BAYER);

    // Effective last column and last row, with out-of-range values clamped.
    always_comb
    begin
        if (cfg.line_width == 9'd0)
        begin
            width_m1 = 8'd0;
        end
        else if (cfg.line_width > 9'(STORE_DEPTH))
        begin
            width_m1 = WIDTH_MAX_M1;
        end
        else
        begin
            width_m1 = 8'(cfg.line_width - 9'd1);
        end
        if (cfg.frame_height == 9'd0)
        begin
            height_m1 = 8'd0;
        end
        else if (cfg.frame_height > 9'(hed_pkg::HEIGHT_LIMIT))
        begin
            height_m1 = 8'(hed_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            height_m1 = 8'(cfg.frame_height - 9'd1);
        end
        col  = (col_cnt_reg > width_m1) ? width_m1 : col_cnt_reg;
        row  = (row_cnt_reg > height_m1) ? height_m1 : row_cnt_reg;
        lend = (col == width_m1);
        fend = lend && (row == height_m1);
    end

    // A row counter left past a shrunken frame keeps its clamped value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bay_row_reg <= '0;
            bay_col_reg <= '0;
        end
        else if (adv && s2_valid_reg && s2_kind_reg == hed_pkg::KIND_FRAME)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            bay_row_reg <= '0;
            bay_col_reg <= '0;
        end
        else if (adv && s2_pixel)
        begin
            if (lend)
            begin
                col_cnt_reg <= '0;
                bay_col_reg <= '0;
                if (fend)
                begin
                    row_cnt_reg <= '0;
                    bay_row_reg <= '0;
                end
                else
                begin
                    row_cnt_reg <= row + 8'd1;
                    if (bayer_mode)
                    begin
                        bay_row_reg <= bay_row_reg + 3'd1;
                    end
                end
            end
            else
            begin
                col_cnt_reg <= col + 8'd1;
                row_cnt_reg <= row;
                if (bayer_mode)
                begin
                    bay_col_reg <= bay_col_reg + 3'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: thresholding and error diffusion.
    // ------------------------------------------------------------------
    logic              s3_valid_reg;
    hed_pkg::kind_t    s3_kind_reg;
    logic [7:0]        s3_level_reg;
    logic [7:0]        s3_col_reg;
    logic [7:0]        s3_row_reg;
    logic              s3_lend_reg;
    logic              s3_fend_reg;
    logic signed [7:0] s3_bayer_reg;
    logic [7:0]        carried_reg;
    logic              s3_pixel;
    logic              s3_frame;
    logic [7:0]        cur_err;
    logic [7:0]        left_err;
    logic signed [9:0] sierra_sum;
    logic signed [9:0] bayer_sum;
    logic [7:0]        err_half;
    logic [7:0]        err_quarter;
    logic              white;
    hed_pkg::err_wr_t  err_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_level_reg <= level;
            s3_col_reg   <= col;
            s3_row_reg   <= row;
            s3_lend_reg  <= lend;
            s3_fend_reg  <= fend;
            s3_bayer_reg <= hed_pkg::BAYER[{bay_row_reg, bay_col_reg}];
        end
    end

    assign s3_pixel = s3_valid_reg && (s3_kind_reg == hed_pkg::KIND_PIXEL);
    assign s3_frame = s3_valid_reg && (s3_kind_reg == hed_pkg::KIND_FRAME);

    hed_err_store #(
        .MAX_LINE (MAX_LINE)
    ) u_err_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .clear    (s3_frame),
        .rd_col   (col),
        .wr       (err_wr),
        .cur_val  (cur_err),
        .left_val (left_err)
    );

    // Sierra Lite: half the error goes right, a quarter down and down-left.
    always_comb
    begin
        sierra_sum  = $signed({2'b00, s3_level_reg})
                    + $signed({{2{carried_reg[7]}}, carried_reg})
                    + $signed({{2{cur_err[7]}}, cur_err});
        bayer_sum   = $signed({2'b00, s3_level_reg})
                    + $signed({{2{s3_bayer_reg[7]}}, s3_bayer_reg});
        err_half    = {sierra_sum[7], sierra_sum[7:1]};
        err_quarter = {err_half[7], err_half[7:1]};

        err_wr.en        = s3_pixel && (cfg.dither_mode == hed_pkg::MODE_SIERRA);
        err_wr.col       = s3_col_reg;
        err_wr.cur_data  = err_quarter;
        err_wr.left_en   = (s3_col_reg != 8'd0);
        err_wr.left_data = left_err + err_quarter;

        case (cfg.dither_mode)
            hed_pkg::MODE_SIERRA: white = (sierra_sum >= hed_pkg::WHITE_CUTOFF);
            hed_pkg::MODE_BAYER:  white = (bayer_sum >= hed_pkg::WHITE_CUTOFF);
            default:              white = s3_level_reg[7];
        endcase
    end

    // Error carried to the right; cleared at each line end and frame start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carried_reg <= '0;
        end
        else if (adv && s3_frame)
        begin
            carried_reg <= '0;
        end
        else if (adv && s3_pixel)
        begin
            if (s3_lend_reg)
            begin
                carried_reg <= '0;
            end
            else if (cfg.dither_mode == hed_pkg::MODE_SIERRA)
            begin
                carried_reg <= err_half;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic       out_white_reg;
    logic [7:0] out_col_reg;
    logic [7:0] out_row_reg;
    logic       out_lend_reg;
    logic       out_fend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s3_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_white_reg <= white;
            out_col_reg   <= s3_col_reg;
            out_row_reg   <= s3_row_reg;
            out_lend_reg  <= s3_lend_reg;
            out_fend_reg  <= s3_fend_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pixel_white = out_white_reg;
    assign results.column      = out_col_reg;
    assign results.row         = out_row_reg;
    assign results.line_end    = out_lend_reg;
    assign results.frame_end   = out_fend_reg;

endmodule

`default_nettype wire

[rtl/hed_checker.sv]
`default_nettype none

module hed_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       pixel_white,
    input wire logic [7:0] column,
    input wire logic [7:0] row,
    input wire logic       line_end,
    input wire logic       frame_end
);

    // A result that waits keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_white) && $stable(column)
                                    && $stable(row) && $stable(line_end) && $stable(frame_end))
        else $error("result changed while stalled");

    // The last pixel of a frame is also the last pixel of its line.
    a_frame_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_end || line_end))
        else $error("frame end without line end");

    // No result is offered while reset is applied.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind histogram_equalize_dither hed_checker u_hed_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .pixel_white (results.pixel_white),
    .column      (results.column),
    .row         (results.row),
    .line_end    (results.line_end),
    .frame_end   (results.frame_end)
);

`default_nettype wire

[verif/hed_dither_checker.sv]
`default_nettype none

// Watches the item, result and configuration ports of the dither block, keeps its own
// copy of the block's state and compares every result transaction with the prediction.
module hed_dither_checker
    import hed_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    hed_in_if                           items,
    hed_out_if                          results,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LIMIT   = (MAX_LINE_DEFAULT < 256) ? MAX_LINE_DEFAULT : 256;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       white;
        logic [7:0] column;
        logic [7:0] row;
        logic       line_end;
        logic       frame_end;
    } dot_t;

    // Output pixels predicted but not yet seen, oldest first.
    dot_t expected_dots[$];

    // Copy of the configuration registers.
    logic [1:0]        mode;
    logic signed [7:0] offset;
    logic              table_on;
    logic [8:0]        width_reg;
    logic [8:0]        height_reg;

    // Copy of the block state.
    logic [7:0]  level_map [LEVELS];
    logic [15:0] cum_count;
    logic [7:0]  err_line [MAX_LINE_DEFAULT];
    logic [7:0]  err_right;
    int          col_pos;
    int          row_pos;
    logic [2:0]  bayer_r;
    logic [2:0]  bayer_c;

    // A frame start rewinds the position counters and wipes the diffusion errors.
    function automatic void clear_frame_state();
        col_pos   = 0;
        row_pos   = 0;
        bayer_r   = '0;
        bayer_c   = '0;
        err_right = '0;
        foreach (err_line[i]) err_line[i] = '0;
    endfunction

    function automatic void restore_defaults();
        mode       = MODE_SIERRA;
        offset     = '0;
        table_on   = 1'b1;
        width_reg  = RESET_LINE_WIDTH;
        height_reg = RESET_FRAME_HEIGHT;
        foreach (level_map[i]) level_map[i] = 8'(i);
        cum_count = '0;
        clear_frame_state();
        expected_dots.delete();
    endfunction

    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DITHER_MODE:       mode       = data[1:0];
            REG_BRIGHTNESS_OFFSET: offset     = data[7:0];
            REG_TABLE_ENABLE:      table_on   = data[0];
            REG_LINE_WIDTH:        width_reg  = data;
            REG_FRAME_HEIGHT:      height_reg = data;
            default: ;
        endcase
    endfunction

    // One histogram bin: extend the running sum and write its level table entry.
    function automatic void accumulate_bin(logic [7:0] bin, logic [15:0] count);
        int level;
        if (bin == 8'd0)
            cum_count = '0;
        cum_count = cum_count + count;
        level = ((int'(cum_count) * 255) >> 8) / 192;
        level_map[bin] = (level > 255) ? 8'd255 : 8'(level);
    endfunction

    // One grey pixel: map, brighten, threshold, and advance the position counters.
    function automatic void convert_pixel(logic [7:0] gray);
        int         w;
        int         h;
        int         c;
        int         t;
        int         s;
        logic [7:0] v;
        logic [7:0] e;
        logic [7:0] half_e;
        logic [7:0] quarter_e;
        dot_t       dot;

        w = (width_reg == 9'd0) ? 1 : int'(width_reg);
        if (w > LINE_LIMIT)
            w = LINE_LIMIT;
        h = (height_reg == 9'd0) ? 1 : int'(height_reg);
        if (h > HEIGHT_LIMIT)
            h = HEIGHT_LIMIT;

        // Counters left past a shrunken line or frame act as the last position.
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        if (row_pos > h - 1)
            row_pos = h - 1;

        v = table_on ? level_map[gray] : gray;
        t = int'(v) + int'(offset);
        if (t < 0)
            t = 0;
        else if (t > 255)
            t = 255;

        case (mode)
            MODE_SIERRA:
            begin
                s         = t + int'($signed(err_right)) + int'($signed(err_line[c]));
                e         = s[7:0];
                half_e    = {e[7], e[7:1]};
                quarter_e = {half_e[7], half_e[7:1]};
                dot.white = s >= int'(WHITE_CUTOFF);
                err_right = half_e;
                err_line[c] = quarter_e;
                if (c > 0)
                    err_line[c-1] = err_line[c-1] + quarter_e;
            end
            MODE_BAYER:
            begin
                s         = t + int'(BAYER[{bayer_r, bayer_c}]);
                dot.white = s >= int'(WHITE_CUTOFF);
                bayer_c   = bayer_c + 3'd1;
            end
            default:
            begin
                dot.white = t >= int'(WHITE_CUTOFF);
            end
        endcase

        dot.column    = 8'(c);
        dot.row       = 8'(row_pos);
        dot.line_end  = c >= w - 1;
        dot.frame_end = dot.line_end && (row_pos >= h - 1);
        expected_dots.push_back(dot);

        if (dot.line_end)
        begin
            col_pos   = 0;
            bayer_c   = '0;
            err_right = '0;
            if (mode == MODE_BAYER)
                bayer_r = bayer_r + 3'd1;
            if (dot.frame_end)
            begin
                row_pos = 0;
                bayer_r = '0;
            end
            else
            begin
                row_pos = row_pos + 1;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    // Sample all three ports at the rising edge; results are checked before new items.
    always @(posedge clk or negedge rst_n)
    begin : watch
        dot_t want;
        dot_t seen;
        if (!rst_n)
        begin
            restore_defaults();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                seen.white     = results.pixel_white;
                seen.column    = results.column;
                seen.row       = results.row;
                seen.line_end  = results.line_end;
                seen.frame_end = results.frame_end;
                if (expected_dots.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result transaction: white=%0d col=%0d row=%0d",
                                 $realtime, seen.white, seen.column, seen.row);
                end
                else
                begin
                    want = expected_dots.pop_front();
                    if (seen != want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected white=%0d col=%0d row=%0d ",
                                      "lend=%0d fend=%0d, got white=%0d col=%0d row=%0d ",
                                      "lend=%0d fend=%0d"},
                                     $realtime, want.white, want.column, want.row,
                                     want.line_end, want.frame_end, seen.white, seen.column,
                                     seen.row, seen.line_end, seen.frame_end);
                    end
                end
            end

            if (cfg_we)
                apply_reg_write(cfg_index, cfg_data);

            if (items.valid && items.ready)
            begin
                case (items.opcode)
                    OP_BIN:   accumulate_bin(items.bin_index, items.bin_count);
                    OP_PIXEL: convert_pixel(items.gray_level);
                    OP_FRAME: clear_frame_state();
                    default: ;
                endcase
            end

            pending = expected_dots.size();
        end
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_PLAIN  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam int ITEM_TARGET   = 2000;
    localparam int CALM_AFTER    = 1700;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int sent         = 0;
    int stall_cycles = 0;
    bit calm         = 1'b0;
    bit hold_armed   = 1'b0;
    bit hold_done    = 1'b0;

    hed_in_if  items_ch ();
    hed_out_if results_ch ();

    histogram_equalize_dither i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hed_dither_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items_ch),
        .results    (results_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: ends the run when no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off to back the block up, and a
    // steady ready in the calm tail of the run.
    initial
    begin : result_sink
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                results_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            else
            begin
                results_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
        end
    end

    // Offer one item, with an occasional gap first, and return at the falling edge
    // after the transaction.
    task automatic send_item(input logic [1:0] op, input logic [7:0] bin,
                             input logic [15:0] count, input logic [7:0] gray);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            items_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        items_ch.valid      <= 1'b1;
        items_ch.opcode     <= op;
        items_ch.bin_index  <= bin;
        items_ch.bin_count  <= count;
        items_ch.gray_level <= gray;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (op != OP_UNUSED)
            sent++;
    endtask

    task automatic send_pixel(input logic [7:0] gray);
        send_item(OP_PIXEL, 8'($urandom), 16'($urandom), gray);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [7:0] offset,
                             input logic table_on, input logic [8:0] width,
                             input logic [8:0] height);
        write_reg(REG_DITHER_MODE, {7'd0, mode});
        write_reg(REG_BRIGHTNESS_OFFSET, {1'b0, offset});
        write_reg(REG_TABLE_ENABLE, {8'd0, table_on});
        write_reg(REG_LINE_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
    endtask

    // Drain all expected pixels, then let in-flight histogram and frame items finish.
    task automatic settle();
        items_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly small sizes so lines and frames close often; a few zero and oversize values.
    function automatic logic [8:0] pick_extent(int common_max);
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            3:       return 9'd1;
            default: return 9'($urandom_range(2, common_max));
        endcase
    endfunction

    function automatic int effective(logic [8:0] extent);
        if (extent == 9'd0)
            return 1;
        return (extent > 9'd256) ? 256 : int'(extent);
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'hFFFF;
            1:       return 16'd0;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 400));
        endcase
    endfunction

    // One random phase: new settings, an optional histogram pass in bin order, an
    // optional frame start, then a pixel stream with a little noise mixed in.
    task automatic run_phase();
        int         r;
        int         npix;
        int         cap;
        int         last_bin;
        logic [8:0] width_val;
        logic [8:0] height_val;
        logic [7:0] offset_val;
        logic [7:0] gray;

        settle();
        width_val  = pick_extent(12);
        height_val = pick_extent(6);
        r = $urandom_range(0, 5);
        offset_val = (r == 0) ? 8'h80 : (r == 1) ? 8'h7F : (r == 2) ? 8'h00 : 8'($urandom);
        configure(2'($urandom_range(0, 3)), offset_val, 1'($urandom),
                  width_val, height_val);
        if ($urandom_range(0, 7) == 0)
            write_reg(3'(REG_FRAME_HEIGHT + $urandom_range(1, 3)), 9'($urandom));

        r = $urandom_range(0, 5);
        if (r <= 2)
        begin
            last_bin = (r == 0) ? LEVELS - 1 : $urandom_range(0, 31);
            for (int b = 0; b <= last_bin; b++)
                send_item(OP_BIN, 8'(b), pick_count(), 8'($urandom));
        end

        if ($urandom_range(0, 1) == 1)
            send_item(OP_FRAME, 8'($urandom), 16'($urandom), 8'($urandom));

        cap  = (effective(width_val) >= 128) ? 300 : 120;
        npix = effective(width_val) * effective(height_val) * $urandom_range(1, 2)
               + $urandom_range(0, 6);
        if (npix > cap)
            npix = cap;
        // Arm the long hold-off only when enough pixels follow to fill the block.
        if (npix >= 60)
            hold_armed = 1'b1;

        for (int i = 0; i < npix; i++)
        begin
            r = $urandom_range(0, 39);
            case (r)
                0: send_item(OP_FRAME, 8'($urandom), 16'($urandom), 8'($urandom));
                1: send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
                2: send_item(OP_BIN, 8'($urandom), pick_count(), 8'($urandom));
                default:
                begin
                    gray = (r == 3) ? 8'd0 : (r == 4) ? 8'hFF : 8'($urandom);
                    send_pixel(gray);
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        items_ch.valid      = 1'b0;
        items_ch.opcode     = OP_BIN;
        items_ch.bin_index  = '0;
        items_ch.bin_count  = '0;
        items_ch.gray_level = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Diffusion with full negative offset; saturated table entry, sum wrap,
        // ignored opcode and a write to a register index past the list.
        configure(MODE_SIERRA, 8'h80, 1'b1, 9'd3, 9'd2);
        write_reg(3'(REG_FRAME_HEIGHT + 3), 9'h1FF);
        send_item(OP_BIN, 8'd0, 16'hFFFF, 8'd0);
        send_item(OP_BIN, 8'd1, 16'd0, 8'd0);
        send_item(OP_BIN, 8'hFF, 16'd1, 8'hFF);
        send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
        send_pixel(8'd0);
        send_pixel(8'hFF);
        send_pixel(8'd1);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'h55);

        // Ordered dither, full positive offset, table bypassed, zero width and height.
        settle();
        configure(MODE_BAYER, 8'h7F, 1'b0, 9'd0, 9'd0);
        send_item(OP_FRAME, 8'h00, 16'h0000, 8'h00);
        send_pixel(8'd0);
        send_pixel(8'hFF);
        send_pixel(8'h80);

        // Unused mode code with oversize width and height.
        settle();
        configure(MODE_UNUSED, 8'h00, 1'b1, 9'h1FF, 9'h1FF);
        send_pixel(8'h7F);
        send_pixel(8'h80);
        send_pixel(8'hC8);

        // Plain threshold after the line shrinks below the current column.
        settle();
        configure(MODE_PLAIN, 8'h01, 1'b1, 9'd2, 9'd1);
        send_pixel(8'd10);
        send_pixel(8'd250);

        // Random phases; the tail of the run goes without idling.
        while (sent < ITEM_TARGET)
        begin
            calm = (sent >= CALM_AFTER);
            run_phase();
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/hed_pkg.sv
rtl/hed_in_if.sv
rtl/hed_out_if.sv
rtl/hed_front.sv
rtl/hed_queue.sv
rtl/hed_err_store.sv
rtl/hed_back.sv
rtl/histogram_equalize_dither.sv
rtl/hed_checker.sv
verif/hed_dither_checker.sv
verif/tb.sv
